@@ rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: command codes,
// field widths, reset values and the result record.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } res_t;

endpackage

@@ rtl/tcw_cell_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Text cell store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH  = DEF_COLUMNS * DEF_ROWS,
  parameter int ADDR_W = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/tcw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer with cursor registers and one shared step adder that
// walks the cell store (init, clear, scroll) and divides a position by the
// row length through repeated subtraction.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int ADDR_W  = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [CMD_W-1:0]  command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  position,
  input  logic [ATTR_W-1:0] attribute,
  input  logic              slot_free,
  output logic              idle,
  output logic              res_load,
  output res_t              res,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [CELL_W-1:0] wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [CELL_W-1:0] rd_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int CMP_W      = (ADDR_W > POS_W ? ADDR_W : POS_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] NEG_COLS  = ADDR_W'((1 << ADDR_W) - COLUMNS);
  localparam logic [ADDR_W-1:0] MOVE_END  = ADDR_W'(MOVE_COUNT);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DIVIDE = 7'b0000100,
    ST_SCROLL = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_CLEAR  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] acc;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  cmd_t              cmd_q;
  logic              hit_q;
  logic              scrolled_q;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;
  logic              pend_mem;

  cmd_t              cmd_in;
  logic              in_fire;
  logic              in_range;
  logic [ADDR_W-1:0] acc_sum;
  logic              last_cell;
  logic              div_more;
  logic              move_phase;
  logic [ADDR_W-1:0] cur_lin;
  logic [CELL_W-1:0] blank;
  logic [ADDR_W-1:0] clamp_pos;

  assign cmd_in   = cmd_t'(command);
  assign idle     = (state == ST_IDLE);
  assign in_fire  = in_valid && idle;
  assign in_range = CMP_W'(position) < CMP_W'(CELL_COUNT);
  assign clamp_pos = in_range ? ADDR_W'(position) : LAST_CELL;
  assign blank    = {attribute, {CHAR_W{1'b0}}};
  assign cur_lin  = ADDR_W'(row) * COLS_A + ADDR_W'(col);

  // shared step unit: sweep increment or subtract one row length
  assign acc_sum    = acc + ((state == ST_DIVIDE) ? NEG_COLS : ADDR_W'(1));
  assign last_cell  = (acc == LAST_CELL);
  assign div_more   = (acc >= COLS_A);
  assign move_phase = (acc < MOVE_END);

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_lin;
    wr_data = {attribute, char_code};
    if (state == ST_INIT) begin
      wr_en   = 1'b1;
      wr_addr = acc;
      wr_data = '0;
    end else if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = acc;
      wr_data = blank;
    end else if (pend_valid) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr;
      wr_data = pend_mem ? rd_data : blank;
    end else if (in_fire) begin
      wr_en   = (cmd_in == CMD_PUT) && (char_code != NEWLINE_CODE);
    end
  end

  // store read port: cell fetch or source row during scroll
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ADDR_W'(position);
    if (state == ST_SCROLL) begin
      rd_en   = move_phase;
      rd_addr = acc + COLS_A;
    end else if (in_fire) begin
      rd_en   = (cmd_in == CMD_READ) && in_range;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      acc        <= '0;
      row        <= '0;
      col        <= '0;
      scrolled_q <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_INIT: begin
          acc <= acc_sum;
          if (last_cell) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            scrolled_q <= 1'b0;
            unique case (cmd_in)
              CMD_PUT: begin
                if (char_code == NEWLINE_CODE || col == LAST_COL) begin
                  col <= '0;
                  if (row == LAST_ROW) begin
                    scrolled_q <= 1'b1;
                    acc        <= '0;
                    state      <= ST_SCROLL;
                  end else begin
                    row   <= row + 1'b1;
                    state <= ST_DONE;
                  end
                end else begin
                  col   <= col + 1'b1;
                  state <= ST_DONE;
                end
              end
              CMD_SET: begin
                acc   <= clamp_pos;
                row   <= '0;
                state <= ST_DIVIDE;
              end
              CMD_READ: begin
                state <= ST_DONE;
              end
              CMD_CLEAR: begin
                acc   <= '0;
                state <= ST_CLEAR;
              end
            endcase
          end
        end
        ST_DIVIDE: begin
          if (div_more) begin
            acc <= acc_sum;
            row <= row + 1'b1;
          end else begin
            col   <= COL_W'(acc);
            state <= ST_DONE;
          end
        end
        ST_SCROLL: begin
          pend_valid <= 1'b1;
          acc        <= acc_sum;
          if (last_cell) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pend_valid <= 1'b0;
          state      <= ST_DONE;
        end
        ST_CLEAR: begin
          acc <= acc_sum;
          if (last_cell) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

  // per command context and pending scroll write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q <= cmd_in;
      hit_q <= in_range;
    end
    if (state == ST_SCROLL) begin
      pend_addr <= acc;
      pend_mem  <= move_phase;
    end
  end

  // result record
  assign res_load       = (state == ST_DONE) && slot_free;
  assign res.cursor_pos = POS_W'(cur_lin);
  assign res.cell_data  = (cmd_q == CMD_READ && hit_q) ? rd_data : '0;
  assign res.scrolled   = scrolled_q;

endmodule

@@ rtl/text_console_writer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console writer: a COLUMNS x ROWS store of 16-bit cells and a cursor,
// driven by put character, set cursor, read cell and clear screen commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the in_valid/in_ready channel (command, char_code,
//   position); each one produces exactly one transaction on out_valid/
//   out_ready (cursor_pos, cell_data, scrolled). The attribute register is
//   written through cfg_valid/cfg_data; cfg_ready is always high.
// Timing:
//   One command is worked at a time; in_ready is low until its result sits
//   in the output register. Set cursor finds the row of the target
//   position by repeated subtraction of COLUMNS, one subtraction per row.
//   A scroll walks the whole store through the single RAM port pair, and
//   so does clear screen.
// Reset:
//   After rst the store is swept to zero with in_ready low; configuration
//   writes are taken.
// Stalls:
//   A finished result waits in the output register while out_ready is low;
//   the next command is accepted meanwhile but holds its result until the
//   output register frees up.
// ----------------------------------------------------------------------------
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  cursor_pos,
  output logic [CELL_W-1:0] cell_data,
  output logic              scrolled,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ATTR_W-1:0] cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam logic [POS_W-1:0] SCROLL_POS = POS_W'((ROWS - 1) * COLUMNS);

  logic [ATTR_W-1:0] attribute;
  logic              slot_free;
  logic              res_load;
  res_t              res;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  // attribute register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
    end else if (cfg_valid) begin
      attribute <= cfg_data;
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .char_code (char_code),
    .position  (position),
    .attribute (attribute),
    .slot_free (slot_free),
    .idle      (in_ready),
    .res_load  (res_load),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  tcw_cell_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  assign slot_free = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      cursor_pos <= res.cursor_pos;
      cell_data  <= res.cell_data;
      scrolled   <= res.scrolled;
    end
  end

  // store sweep after reset blocks commands
  a_init_blocks: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("command channel open right after reset");

  // an accepted command takes the sequencer out of idle, which drops in_ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while previous one still in flight");

  // a scroll always leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> cursor_pos == SCROLL_POS)
    else $error("scroll reported with cursor off the last row start");

  // a loaded result shows up on the output next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_valid)
    else $error("result load lost");

endmodule

@@ dv/text_console_writer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the command, status and attribute channels of the console writer,
// keeps its own copy of the screen, cursor and attribute, and compares every
// status transaction with the one its copy predicts, oldest first.
// ----------------------------------------------------------------------------
module text_console_writer_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [POS_W-1:0]  position,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [POS_W-1:0]  cursor_pos,
  input  logic [CELL_W-1:0] cell_data,
  input  logic              scrolled,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [ATTR_W-1:0] cfg_data,
  input  logic              drain_check,
  output int                outstanding,
  output int                fail_count
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int MAX_PRINTS = 40;

  // shadow copy of the console
  logic [CELL_W-1:0] shadow_cells [CELLS];
  logic [ATTR_W-1:0] shadow_attr;
  int                shadow_col;
  int                shadow_row;

  res_t status_q [$];
  int   mismatches        = 0;
  int   open_count        = 0;
  bit   leftover_reported = 1'b0;

  assign outstanding = open_count;
  assign fail_count  = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [CELL_W-1:0] blank_cell();
    return {shadow_attr, {CHAR_W{1'b0}}};
  endfunction

  // column 0 of the next row, scrolling the store when the bottom is passed
  function automatic logic advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row < ROWS)
      return 1'b0;
    for (int i = 0; i < CELLS - COLUMNS; i++)
      shadow_cells[i] = shadow_cells[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++)
      shadow_cells[i] = blank_cell();
    shadow_row = ROWS - 1;
    return 1'b1;
  endfunction

  // apply one command to the shadow console and return its status
  function automatic res_t execute_command(input cmd_t op, input logic [CHAR_W-1:0] code,
                                           input logic [POS_W-1:0] pos);
    res_t status;
    int   target;
    status = '0;
    case (op)
      CMD_PUT: begin
        if (code == NEWLINE_CODE) begin
          status.scrolled = advance_line();
        end else begin
          shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, code};
          shadow_col++;
          if (shadow_col >= COLUMNS)
            status.scrolled = advance_line();
        end
      end
      CMD_SET: begin
        target     = (int'(pos) >= CELLS) ? CELLS - 1 : int'(pos);
        shadow_col = target % COLUMNS;
        shadow_row = target / COLUMNS;
      end
      CMD_READ: begin
        if (int'(pos) < CELLS)
          status.cell_data = shadow_cells[pos];
      end
      default: begin
        for (int i = 0; i < CELLS; i++)
          shadow_cells[i] = blank_cell();
      end
    endcase
    status.cursor_pos = POS_W'(shadow_row * COLUMNS + shadow_col);
    return status;
  endfunction

  // track transactions, predict and compare
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++)
        shadow_cells[i] = '0;
      shadow_attr = ATTR_RESET;
      shadow_col  = 0;
      shadow_row  = 0;
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        shadow_attr = cfg_data;
      if (in_valid && in_ready)
        status_q.push_back(execute_command(cmd_t'(command), char_code, position));
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("status with none expected: pos %0d cell %h scrolled %b",
                                    cursor_pos, cell_data, scrolled));
        end else begin
          want = status_q.pop_front();
          if (cursor_pos !== want.cursor_pos)
            report_mismatch($sformatf("cursor_pos got %0d want %0d",
                                      cursor_pos, want.cursor_pos));
          if (cell_data !== want.cell_data)
            report_mismatch($sformatf("cell_data got %h want %h", cell_data, want.cell_data));
          if (scrolled !== want.scrolled)
            report_mismatch($sformatf("scrolled got %b want %b", scrolled, want.scrolled));
        end
      end
      // anything still waiting once the run has drained
      if (drain_check && !leftover_reported) begin
        leftover_reported = 1'b1;
        if (status_q.size() != 0)
          report_mismatch($sformatf("%0d status transactions never arrived", status_q.size()));
      end
    end
    open_count <= status_q.size();
  end

endmodule

@@ dv/tb_text_console_writer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// Drives the console writer with directed commands and then random command
// sequences (typed lines, bottom-row wraps that scroll, clears, noise) under
// several idle and stall mixes and attribute settings; the checker predicts
// and compares every status transaction.
// ----------------------------------------------------------------------------
module tb_text_console_writer_core;
  import tcw_pkg::*;

  // longest quiet stretch: reset sweep or a scroll/clear on top of the long
  // receiver hold-off, taken several times over
  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 312;
  localparam int LAST_ROW_POS = (DEF_ROWS - 1) * DEF_COLUMNS;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command   = CMD_PUT;
  logic [CHAR_W-1:0] char_code = '0;
  logic [POS_W-1:0]  position  = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  cursor_pos;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ATTR_W-1:0] cfg_data  = '0;
  logic              drain_check = 1'b0;

  int outstanding;
  int fail_count;
  int quiet_cycles  = 0;
  int items_sent    = 0;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_served  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_writer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .char_code (char_code),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cursor_pos(cursor_pos),
    .cell_data (cell_data),
    .scrolled  (scrolled),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  text_console_writer_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .char_code  (char_code),
    .position   (position),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_pos (cursor_pos),
    .cell_data  (cell_data),
    .scrolled   (scrolled),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .drain_check(drain_check),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // status receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [CHAR_W-1:0] any_byte();
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [POS_W-1:0] any_pos();
    return POS_W'($urandom_range(2047));
  endfunction

  // typed character, newline now and then
  function automatic logic [CHAR_W-1:0] typed_char(input int newline_pct);
    return ($urandom_range(99) < newline_pct) ? NEWLINE_CODE : any_byte();
  endfunction

  // one command transaction, after a random sender gap
  task automatic send_command(input cmd_t op, input logic [CHAR_W-1:0] code,
                              input logic [POS_W-1:0] pos);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= op;
    char_code <= code;
    position  <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and wait for every predicted status
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // place the cursor away from the bottom, type a few characters, read back
  task automatic type_line();
    int start, count;
    start = $urandom_range(DEF_ROWS - 2) * DEF_COLUMNS + $urandom_range(DEF_COLUMNS - 1);
    count = $urandom_range(3, 16);
    send_command(CMD_SET, any_byte(), POS_W'(start));
    repeat (count) send_command(CMD_PUT, typed_char(10), any_pos());
    repeat ($urandom_range(1, 3))
      send_command(CMD_READ, any_byte(), POS_W'(start + $urandom_range(count)));
  endtask

  // near the end of the last row, so the row end or a newline scrolls
  task automatic type_into_bottom_row();
    send_command(CMD_SET, any_byte(),
                 POS_W'(LAST_ROW_POS + DEF_COLUMNS - 1 - $urandom_range(5)));
    repeat ($urandom_range(1, 8)) send_command(CMD_PUT, typed_char(20), any_pos());
    repeat (2)
      send_command(CMD_READ, any_byte(),
                   POS_W'(LAST_ROW_POS - DEF_COLUMNS + $urandom_range(2 * DEF_COLUMNS - 1)));
  endtask

  // random sequences; mid-phase a long hold-off or a full pause
  task automatic run_phase(input int count, input bit with_hold, input bit with_pause);
    int  start, pick;
    bit  midway_done;
    start       = items_sent;
    midway_done = 1'b0;
    while (items_sent - start < count) begin
      if (!midway_done && items_sent - start >= count / 2) begin
        midway_done = 1'b1;
        if (with_hold) hold_requests++;
        if (with_pause) wait_drained();
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 3))
          send_command(cmd_t'($urandom_range(3)), any_byte(), any_pos());
      end else if (pick < 22) begin
        type_into_bottom_row();
      end else if (pick < 25) begin
        send_command(CMD_CLEAR, any_byte(), any_pos());
        send_command(CMD_READ, any_byte(), any_pos());
      end else begin
        type_line();
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset attribute
    send_command(CMD_READ,  8'h00,        11'd0);      // store cleared at reset
    send_command(CMD_READ,  8'hFF,        11'd1999);
    send_command(CMD_PUT,   8'h41,        11'd0);
    send_command(CMD_PUT,   8'h80,        11'd0);      // high bit set, unsigned
    send_command(CMD_PUT,   8'h00,        11'd0);
    send_command(CMD_READ,  8'h00,        11'd0);
    send_command(CMD_PUT,   NEWLINE_CODE, 11'd0);      // newline stores nothing
    send_command(CMD_SET,   8'h00,        11'd79);
    send_command(CMD_PUT,   8'hFF,        11'd0);      // row end wraps
    send_command(CMD_SET,   8'h00,        11'd2047);   // clamps to the last cell
    send_command(CMD_PUT,   8'h7A,        11'd0);      // row end on last row scrolls
    send_command(CMD_READ,  8'h00,        11'd1919);
    send_command(CMD_READ,  8'h00,        11'd1920);   // blank fill
    send_command(CMD_PUT,   NEWLINE_CODE, 11'd0);      // newline on last row scrolls
    send_command(CMD_SET,   8'h00,        11'd2000);
    send_command(CMD_READ,  8'h00,        11'd2000);   // out of range reads zero
    send_command(CMD_READ,  8'h00,        11'd2047);
    send_command(CMD_SET,   8'h00,        11'd1024);
    send_command(CMD_CLEAR, 8'h00,        11'd0);      // cursor stays put
    send_command(CMD_READ,  8'h00,        11'd0);
    send_command(CMD_PUT,   8'h7F,        11'd0);
    send_command(CMD_READ,  8'h00,        11'd1024);

    // random phases, attribute rewritten while idle
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  write_attribute(8'h00); end
        1: begin idle_pct = 52; stall_pct = 0;  write_attribute(8'hFF); end
        2: begin idle_pct = 0;  stall_pct = 52; write_attribute(ATTR_W'($urandom_range(255))); end
        default: begin idle_pct = 25; stall_pct = 25; write_attribute(8'h80); end
      endcase
      run_phase(PHASE_ITEMS, phase == 0, phase == 2);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    drain_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_core.sv
dv/text_console_writer_checker.sv
dv/tb_text_console_writer_core.sv
